/* rtl/core/dasu_pkg.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dasu_pkg
// Types, codes and frame constants shared by the DALI address search
// sequencer.
// ----------------------------------------------------------------------------
package dasu_pkg;

    // Event kinds on the input channel.
    typedef enum logic [1:0] {
        OP_START  = 2'd0,
        OP_RESULT = 2'd1,
        OP_TICK   = 2'd2,
        OP_NONE   = 2'd3
    } t_op;

    // Transaction result codes.
    localparam logic [2:0] RC_SUCCESS      = 3'd0;
    localparam logic [2:0] RC_SEND_FAILED  = 3'd1;
    localparam logic [2:0] RC_NO_REPLY     = 3'd2;
    localparam logic [2:0] RC_GOOD_REPLY   = 3'd3;
    localparam logic [2:0] RC_WRONG_LENGTH = 3'd4;
    localparam logic [2:0] RC_TIMING_ERROR = 3'd5;

    // Send priorities.
    localparam logic [1:0] PRIO_TRANSACTION = 2'd0;
    localparam logic [1:0] PRIO_AUTOMATIC   = 2'd1;
    localparam logic [1:0] PRIO_CONFIG      = 2'd2;

    // Configuration register indexes.
    localparam logic [1:0] CFG_RESET_WAIT     = 2'd0;
    localparam logic [1:0] CFG_RANDOMISE_WAIT = 2'd1;
    localparam logic [1:0] CFG_RESET_CMD      = 2'd2;
    localparam logic [1:0] CFG_OFF_CMD        = 2'd3;

    localparam int CFG_INDEX_W = 2;
    localparam int CFG_DATA_W  = 16;

    // Reset values of the configuration registers.
    localparam logic [15:0] RESET_WAIT_DEFAULT     = 16'd350;
    localparam logic [15:0] RANDOMISE_WAIT_DEFAULT = 16'd100;
    localparam logic [7:0]  RESET_CMD_DEFAULT      = 8'd32;
    localparam logic [7:0]  OFF_CMD_DEFAULT        = 8'd0;

    // Forward frame address bytes.
    localparam logic [7:0] FWD_BCAST    = 8'hFF;
    localparam logic [7:0] FWD_TERM     = 8'hA1;
    localparam logic [7:0] FWD_INIT     = 8'hA5;
    localparam logic [7:0] FWD_RAND     = 8'hA7;
    localparam logic [7:0] FWD_CMP      = 8'hA9;
    localparam logic [7:0] FWD_WDRAW    = 8'hAB;
    localparam logic [7:0] FWD_SRCH_H   = 8'hB1;
    localparam logic [7:0] FWD_SRCH_M   = 8'hB3;
    localparam logic [7:0] FWD_SRCH_L   = 8'hB5;
    localparam logic [7:0] FWD_PROG     = 8'hB7;
    localparam logic [7:0] FWD_VERIFY   = 8'hB9;

    localparam logic [23:0] SEARCH_TOP = 24'hFFFFFE;
    localparam logic [15:0] WAIT_MAX   = 16'hFFFF;

    typedef enum logic [3:0] {
        PH_INACTIVE       = 4'd0,
        PH_RESET          = 4'd1,
        PH_RESET_WAIT     = 4'd2,
        PH_LAMP_OFF       = 4'd3,
        PH_INITIALISE     = 4'd4,
        PH_RANDOMISE      = 4'd5,
        PH_RANDOMISE_WAIT = 4'd6,
        PH_SEARCH_H       = 4'd7,
        PH_SEARCH_M       = 4'd8,
        PH_SEARCH_L       = 4'd9,
        PH_COMPARE        = 4'd10,
        PH_PROGRAM        = 4'd11,
        PH_VERIFY         = 4'd12,
        PH_WITHDRAW       = 4'd13
    } t_phase;

    typedef struct packed {
        logic [15:0] reset_wait_ticks;
        logic [15:0] randomise_wait_ticks;
        logic [7:0]  reset_command;
        logic [7:0]  off_command;
    } t_cfg;

    typedef struct packed {
        t_phase      phase;
        logic [23:0] search_min;
        logic [23:0] search_max;
        logic [23:0] search_mid;
        logic [6:0]  next_short;
        logic [15:0] wait_count;
    } t_state;

    typedef struct packed {
        logic       valid;
        logic [7:0] address;
        logic [7:0] data;
        logic       twice;
        logic       expect_reply;
        logic [1:0] priority_code;
    } t_frame;

    typedef struct packed {
        t_frame      frame;
        logic        busy_res;
        logic        finished_ok;
        logic        finished_fail;
        logic [6:0]  lamps_found;
        logic [23:0] search_low;
    } t_result;

    function automatic t_frame mk_frame(
        input logic [7:0] address,
        input logic [7:0] data,
        input logic       twice,
        input logic       expect_reply,
        input logic [1:0] priority_code
    );
        t_frame f;
        f.valid         = 1'b1;
        f.address       = address;
        f.data          = data;
        f.twice         = twice;
        f.expect_reply  = expect_reply;
        f.priority_code = priority_code;
        return f;
    endfunction

endpackage

/* rtl/core/dasu_step.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dasu_step
// Next-state and result logic of the sequencer for one event.
// ----------------------------------------------------------------------------
module dasu_step (
    input  dasu_pkg::t_cfg    i_cfg,
    input  dasu_pkg::t_state  i_state,
    input  logic [1:0]        i_op,
    input  logic [2:0]        i_result_code,
    output dasu_pkg::t_state  o_state,
    output dasu_pkg::t_result o_result
);
    import dasu_pkg::*;

    t_state      s;
    t_frame      frame;
    logic        ok;
    logic        fail;
    logic        accepted;
    logic [24:0] sum_up;
    logic [24:0] sum_down;
    logic [23:0] min_inc;
    logic [15:0] wait_inc;
    logic [7:0]  short_data;

    // The new lower bound after a no-reply compare, and both candidate sums.
    assign min_inc    = i_state.search_mid + 24'd1;
    assign sum_up     = {1'b0, min_inc} + {1'b0, i_state.search_max};
    assign sum_down   = {1'b0, i_state.search_min} + {1'b0, i_state.search_mid};
    assign wait_inc   = (i_state.wait_count == WAIT_MAX) ? WAIT_MAX
                                                         : i_state.wait_count + 16'd1;
    assign short_data = {i_state.next_short, 1'b1};

    always_comb begin
        s        = i_state;
        frame    = '0;
        ok       = 1'b0;
        fail     = 1'b0;
        accepted = 1'b0;

        unique case (t_op'(i_op))
            OP_START: begin
                if (i_state.phase == PH_INACTIVE) begin
                    s.search_min = '0;
                    s.search_max = '0;
                    s.search_mid = '0;
                    s.next_short = '0;
                    s.wait_count = '0;
                    s.phase      = PH_RESET;
                    frame = mk_frame(FWD_BCAST, i_cfg.reset_command, 1'b0, 1'b0,
                                     PRIO_CONFIG);
                end
            end
            OP_RESULT: begin
                if (i_state.phase != PH_INACTIVE && i_state.phase != PH_RESET_WAIT &&
                    i_state.phase != PH_RANDOMISE_WAIT) begin
                    if (i_state.phase == PH_COMPARE) begin
                        accepted = (i_result_code >= RC_NO_REPLY) &&
                                   (i_result_code <= RC_TIMING_ERROR);
                    end else if (i_state.phase == PH_VERIFY) begin
                        accepted = (i_result_code == RC_GOOD_REPLY);
                    end else begin
                        accepted = (i_result_code == RC_SUCCESS);
                    end

                    if (!accepted) begin
                        // Once initialise went out, the lamps must be told to stop.
                        if (i_state.phase >= PH_INITIALISE) begin
                            frame = mk_frame(FWD_TERM, 8'h00, 1'b0, 1'b0,
                                             PRIO_AUTOMATIC);
                        end
                        s.phase = PH_INACTIVE;
                        fail    = 1'b1;
                    end else begin
                        unique case (i_state.phase)
                            PH_RESET: begin
                                s.phase      = PH_RESET_WAIT;
                                s.wait_count = '0;
                            end
                            PH_LAMP_OFF: begin
                                frame = mk_frame(FWD_INIT, 8'h00, 1'b1, 1'b0,
                                                 PRIO_TRANSACTION);
                                s.phase = PH_INITIALISE;
                            end
                            PH_INITIALISE: begin
                                frame = mk_frame(FWD_RAND, 8'h00, 1'b1, 1'b0,
                                                 PRIO_TRANSACTION);
                                s.phase = PH_RANDOMISE;
                            end
                            PH_RANDOMISE: begin
                                s.phase      = PH_RANDOMISE_WAIT;
                                s.wait_count = '0;
                            end
                            PH_SEARCH_H: begin
                                frame = mk_frame(FWD_SRCH_M, i_state.search_mid[15:8],
                                                 1'b0, 1'b0, PRIO_TRANSACTION);
                                s.phase = PH_SEARCH_M;
                            end
                            PH_SEARCH_M: begin
                                frame = mk_frame(FWD_SRCH_L, i_state.search_mid[7:0],
                                                 1'b0, 1'b0, PRIO_TRANSACTION);
                                s.phase = PH_SEARCH_L;
                            end
                            PH_SEARCH_L: begin
                                frame = mk_frame(FWD_CMP, 8'h00, 1'b0, 1'b1,
                                                 PRIO_TRANSACTION);
                                s.phase = PH_COMPARE;
                            end
                            PH_COMPARE: begin
                                if (i_result_code == RC_NO_REPLY) begin
                                    // No lamp at or below the midpoint: raise the floor.
                                    s.search_min = min_inc;
                                    if (min_inc > i_state.search_max) begin
                                        frame = mk_frame(FWD_TERM, 8'h00, 1'b0,
                                                         1'b0, PRIO_AUTOMATIC);
                                        s.phase = PH_INACTIVE;
                                        ok      = 1'b1;
                                    end else begin
                                        s.search_mid = sum_up[24:1];
                                        frame = mk_frame(FWD_SRCH_H, sum_up[24:17],
                                                         1'b0, 1'b0, PRIO_TRANSACTION);
                                        s.phase = PH_SEARCH_H;
                                    end
                                end else if (i_state.search_min == i_state.search_max) begin
                                    frame = mk_frame(FWD_PROG, short_data, 1'b0, 1'b0,
                                                     PRIO_TRANSACTION);
                                    s.phase = PH_PROGRAM;
                                end else begin
                                    s.search_max = i_state.search_mid;
                                    s.search_mid = sum_down[24:1];
                                    frame = mk_frame(FWD_SRCH_H, sum_down[24:17],
                                                     1'b0, 1'b0, PRIO_TRANSACTION);
                                    s.phase = PH_SEARCH_H;
                                end
                            end
                            PH_PROGRAM: begin
                                frame = mk_frame(FWD_VERIFY, short_data, 1'b0, 1'b1,
                                                 PRIO_TRANSACTION);
                                s.phase      = PH_VERIFY;
                                s.next_short = i_state.next_short + 7'd1;
                            end
                            PH_VERIFY: begin
                                frame = mk_frame(FWD_WDRAW, 8'h00, 1'b0, 1'b0,
                                                 PRIO_TRANSACTION);
                                s.phase = PH_WITHDRAW;
                            end
                            PH_WITHDRAW: begin
                                // Midpoint of the full range is a fixed value.
                                s.search_min = '0;
                                s.search_max = SEARCH_TOP;
                                s.search_mid = SEARCH_TOP >> 1;
                                frame = mk_frame(FWD_SRCH_H, 8'h7F, 1'b0, 1'b0,
                                                 PRIO_TRANSACTION);
                                s.phase = PH_SEARCH_H;
                            end
                            default: begin
                            end
                        endcase
                    end
                end
            end
            OP_TICK: begin
                if (i_state.phase == PH_RESET_WAIT) begin
                    s.wait_count = wait_inc;
                    if (wait_inc >= i_cfg.reset_wait_ticks) begin
                        frame = mk_frame(FWD_BCAST, i_cfg.off_command, 1'b1, 1'b0,
                                         PRIO_TRANSACTION);
                        s.phase = PH_LAMP_OFF;
                    end
                end else if (i_state.phase == PH_RANDOMISE_WAIT) begin
                    s.wait_count = wait_inc;
                    if (wait_inc >= i_cfg.randomise_wait_ticks) begin
                        s.search_min = '0;
                        s.search_max = SEARCH_TOP;
                        s.search_mid = SEARCH_TOP >> 1;
                        frame = mk_frame(FWD_SRCH_H, 8'h7F, 1'b0, 1'b0,
                                         PRIO_TRANSACTION);
                        s.phase = PH_SEARCH_H;
                    end
                end
            end
            default: begin
            end
        endcase
    end

    assign o_state                = s;
    assign o_result.frame         = frame;
    assign o_result.busy_res      = (s.phase != PH_INACTIVE);
    assign o_result.finished_ok   = ok;
    assign o_result.finished_fail = fail;
    assign o_result.lamps_found   = s.next_short;
    assign o_result.search_low    = s.search_min;

endmodule

/* rtl/core/dasu_out_buf.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dasu_out_buf
// Two-entry result buffer that lets the input side keep going while a
// result waits to be taken.
// ----------------------------------------------------------------------------
module dasu_out_buf (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_push,
    input  dasu_pkg::t_result i_data,
    output logic              o_space,
    output logic              o_valid,
    input  logic              i_ready,
    output dasu_pkg::t_result o_data
);
    import dasu_pkg::*;

    t_result    r_head;
    t_result    r_tail;
    logic [1:0] r_count;
    logic [1:0] n_count;
    logic       pop;

    assign pop     = (r_count != 2'd0) && i_ready;
    assign o_space = (r_count != 2'd2);
    assign o_valid = (r_count != 2'd0);
    assign o_data  = r_head;

    always_comb begin
        n_count = r_count;
        if (i_push && !pop) begin
            n_count = r_count + 2'd1;
        end else if (!i_push && pop) begin
            n_count = r_count - 2'd1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count <= 2'd0;
        end else begin
            r_count <= n_count;
        end
    end

    always_ff @(posedge i_clk) begin
        if (pop) begin
            if (r_count == 2'd2) begin
                r_head <= r_tail;
            end else if (i_push) begin
                r_head <= i_data;
            end
        end else if (i_push) begin
            if (r_count == 2'd0) begin
                r_head <= i_data;
            end else begin
                r_tail <= i_data;
            end
        end
        if (pop && i_push && r_count == 2'd2) begin
            r_tail <= i_data;
        end
    end

endmodule

/* rtl/core/dali_address_search_sequencer_unit.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dali_address_search_sequencer_unit
// DALI short-address assignment sequencer: a random long-address binary
// search driven by start, transaction-result and timer-tick events.
// ----------------------------------------------------------------------------
//
//  Channel   Direction  Handshake            Payload
//  events    in         i_valid / o_ready    i_op, i_result_code
//  results   out        o_valid / i_ready    o_cmd_*, status, o_search_low
//  config    in         i_cfg_we             i_cfg_index, i_cfg_data
//
// Every event transfer yields exactly one result transfer. The event is
// evaluated in the cycle it is accepted and its result is written into a
// two-entry output buffer, whose head drives the result outputs. One event
// can be taken every cycle while a buffer entry is free; o_ready drops only
// when both buffer entries hold results the downstream side has not yet
// taken, and the buffer depth sets that stall point. Reset (synchronous,
// active low) puts the sequencer in its inactive phase, clears the search
// state and loads the default configuration values.
//
module dali_address_search_sequencer_unit (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  logic                               i_valid,
    output logic                               o_ready,
    input  logic [1:0]                         i_op,
    input  logic [2:0]                         i_result_code,
    output logic                               o_valid,
    input  logic                               i_ready,
    output logic                               o_cmd_valid,
    output logic [7:0]                         o_cmd_address,
    output logic [7:0]                         o_cmd_data,
    output logic                               o_cmd_twice,
    output logic                               o_cmd_expect_reply,
    output logic [1:0]                         o_cmd_priority,
    output logic                               o_busy_res,
    output logic                               o_finished_ok,
    output logic                               o_finished_fail,
    output logic [6:0]                         o_lamps_found,
    output logic [23:0]                        o_search_low,
    input  logic                               i_cfg_we,
    input  logic [dasu_pkg::CFG_INDEX_W-1:0]   i_cfg_index,
    input  logic [dasu_pkg::CFG_DATA_W-1:0]    i_cfg_data
);
    import dasu_pkg::*;

    t_cfg    r_cfg;
    t_state  r_state;
    t_state  n_state;
    t_result step_result;
    t_result head;
    logic    accept;

    assign accept = i_valid && o_ready;

    // Configuration registers. Writes must arrive only while the sequencer is idle; the block does not enforce it.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.reset_wait_ticks     <= RESET_WAIT_DEFAULT;
            r_cfg.randomise_wait_ticks <= RANDOMISE_WAIT_DEFAULT;
            r_cfg.reset_command        <= RESET_CMD_DEFAULT;
            r_cfg.off_command          <= OFF_CMD_DEFAULT;
        end else if (i_cfg_we) begin
            unique case (i_cfg_index)
                CFG_RESET_WAIT:     r_cfg.reset_wait_ticks     <= i_cfg_data;
                CFG_RANDOMISE_WAIT: r_cfg.randomise_wait_ticks <= i_cfg_data;
                CFG_RESET_CMD:      r_cfg.reset_command        <= i_cfg_data[7:0];
                CFG_OFF_CMD:        r_cfg.off_command          <= i_cfg_data[7:0];
                default: begin
                end
            endcase
        end
    end

    // Sequencer state advances only on an accepted event.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state.phase      <= PH_INACTIVE;
            r_state.search_min <= '0;
            r_state.search_max <= '0;
            r_state.search_mid <= '0;
            r_state.next_short <= '0;
            r_state.wait_count <= '0;
        end else if (accept) begin
            r_state <= n_state;
        end
    end

    dasu_step u_step (
        .i_cfg         (r_cfg),
        .i_state       (r_state),
        .i_op          (i_op),
        .i_result_code (i_result_code),
        .o_state       (n_state),
        .o_result      (step_result)
    );

    dasu_out_buf u_out_buf (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (accept),
        .i_data  (step_result),
        .o_space (o_ready),
        .o_valid (o_valid),
        .i_ready (i_ready),
        .o_data  (head)
    );

    assign o_cmd_valid        = head.frame.valid;
    assign o_cmd_address      = head.frame.address;
    assign o_cmd_data         = head.frame.data;
    assign o_cmd_twice        = head.frame.twice;
    assign o_cmd_expect_reply = head.frame.expect_reply;
    assign o_cmd_priority     = head.frame.priority_code;
    assign o_busy_res         = head.busy_res;
    assign o_finished_ok      = head.finished_ok;
    assign o_finished_fail    = head.finished_fail;
    assign o_lamps_found      = head.lamps_found;
    assign o_search_low       = head.search_low;

`ifndef NO_ASSERTIONS
    // A start from the inactive phase always leads into the reset phase.
    a_start_enters_reset: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (accept && i_op == OP_START && r_state.phase == PH_INACTIVE)
        |=> (r_state.phase == PH_RESET))
        else $error("start from inactive did not enter reset phase");

    // Without an accepted event the phase holds.
    a_phase_holds: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !accept |=> $stable(r_state.phase))
        else $error("phase moved without an accepted event");

    // An accepted event always leaves a result to deliver.
    a_result_follows: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        accept |=> o_valid)
        else $error("accepted event produced no pending result");

    // A sequence that ends reports idle and only one ending.
    a_finish_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && (o_finished_ok || o_finished_fail))
        |-> (!o_busy_res && !(o_finished_ok && o_finished_fail)))
        else $error("finished result is inconsistent");

    // Search bounds stay ordered while the binary search is running.
    a_bounds_ordered: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state.phase == PH_SEARCH_H || r_state.phase == PH_SEARCH_M ||
         r_state.phase == PH_SEARCH_L || r_state.phase == PH_COMPARE)
        |-> (r_state.search_min <= r_state.search_mid &&
             r_state.search_mid <= r_state.search_max))
        else $error("search bounds out of order");
`endif

endmodule

/* tb/dali_address_search_sequencer_unit_test.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dali_address_search_sequencer_unit_test
// Self-checking bench for the DALI address search sequencer. Each event
// transfer is mirrored in a cycle-free model of the phase machine. The
// predicted result is queued and compared field by field with every result
// transfer. A small bus model answers the frames like a set of lamps with
// random long addresses, so most traffic walks through complete searches.
// ----------------------------------------------------------------------------
module dali_address_search_sequencer_unit_test;
    import dasu_pkg::*;

    // Clock, reset and block inputs. Every input has a known value from time 0.
    logic                    i_clk         = 1'b0;
    logic                    i_rst_n       = 1'b0;
    logic                    i_valid       = 1'b0;
    logic [1:0]              i_op          = OP_NONE;
    logic [2:0]              i_result_code = RC_SUCCESS;
    logic                    i_ready       = 1'b0;
    logic                    i_cfg_we      = 1'b0;
    logic [CFG_INDEX_W-1:0]  i_cfg_index   = CFG_RESET_WAIT;
    logic [CFG_DATA_W-1:0]   i_cfg_data    = '0;

    logic                    o_ready;
    logic                    o_valid;
    logic                    o_cmd_valid;
    logic [7:0]              o_cmd_address;
    logic [7:0]              o_cmd_data;
    logic                    o_cmd_twice;
    logic                    o_cmd_expect_reply;
    logic [1:0]              o_cmd_priority;
    logic                    o_busy_res;
    logic                    o_finished_ok;
    logic                    o_finished_fail;
    logic [6:0]              o_lamps_found;
    logic [23:0]             o_search_low;

    dali_address_search_sequencer_unit dut (
        .i_clk              (i_clk),
        .i_rst_n            (i_rst_n),
        .i_valid            (i_valid),
        .o_ready            (o_ready),
        .i_op               (i_op),
        .i_result_code      (i_result_code),
        .o_valid            (o_valid),
        .i_ready            (i_ready),
        .o_cmd_valid        (o_cmd_valid),
        .o_cmd_address      (o_cmd_address),
        .o_cmd_data         (o_cmd_data),
        .o_cmd_twice        (o_cmd_twice),
        .o_cmd_expect_reply (o_cmd_expect_reply),
        .o_cmd_priority     (o_cmd_priority),
        .o_busy_res         (o_busy_res),
        .o_finished_ok      (o_finished_ok),
        .o_finished_fail    (o_finished_fail),
        .o_lamps_found      (o_lamps_found),
        .o_search_low       (o_search_low),
        .i_cfg_we           (i_cfg_we),
        .i_cfg_index        (i_cfg_index),
        .i_cfg_data         (i_cfg_data)
    );

    // 2 ns clock period.
    always #1 i_clk = ~i_clk;

    // Percentage of cycles in which the event sender and the result receiver
    // hold off. The test sequence changes them between phases of the run.
    int tx_idle_pct = 0;
    int rx_idle_pct = 0;

    // Mirror of the sequencer: configuration and phase machine state.
    t_cfg        cfg_shadow = '{reset_wait_ticks:     RESET_WAIT_DEFAULT,
                                randomise_wait_ticks: RANDOMISE_WAIT_DEFAULT,
                                reset_command:        RESET_CMD_DEFAULT,
                                off_command:          OFF_CMD_DEFAULT};
    t_phase      seq_phase = PH_INACTIVE;
    logic [23:0] seq_min   = '0;
    logic [23:0] seq_max   = '0;
    logic [23:0] seq_mid   = '0;
    logic [6:0]  seq_short = '0;
    logic [15:0] seq_wait  = '0;

    // Results predicted for accepted events, oldest first.
    t_result     frames_due[$];
    t_result     due;

    // Long addresses of the lamps the bus model pretends are still searchable.
    logic [23:0] lamp_addrs[$];

    // Events that changed the sequencer; ignored events are not counted.
    int          events_applied = 0;
    int          mismatches     = 0;

    // ------------------------------------------------------------------------
    // Model of the phase machine
    // ------------------------------------------------------------------------

    // Which result codes a phase takes as a good outcome. The compare phase
    // takes every reply outcome, verify needs a good reply, the rest success.
    function automatic bit rc_accepted(input t_phase ph, input logic [2:0] rc);
        if (ph == PH_COMPARE)
            return (rc >= RC_NO_REPLY) && (rc <= RC_TIMING_ERROR);
        if (ph == PH_VERIFY)
            return rc == RC_GOOD_REPLY;
        return rc == RC_SUCCESS;
    endfunction

    function automatic t_frame frame_of(input logic [7:0] addr, input logic [7:0] data,
                                        input logic twice, input logic reply,
                                        input logic [1:0] prio);
        t_frame f;
        f.valid         = 1'b1;
        f.address       = addr;
        f.data          = data;
        f.twice         = twice;
        f.expect_reply  = reply;
        f.priority_code = prio;
        return f;
    endfunction

    // Ends the sequence. A terminate frame goes out only once initialise
    // has been sent.
    task automatic conclude(input bit ok, inout t_result r);
        if (seq_phase >= PH_INITIALISE)
            r.frame = frame_of(FWD_TERM, 8'h00, 1'b0, 1'b0, PRIO_AUTOMATIC);
        seq_phase = PH_INACTIVE;
        if (ok)
            r.finished_ok = 1'b1;
        else
            r.finished_fail = 1'b1;
    endtask

    // Starts one search round at the midpoint of the bounds, optionally
    // reopening the whole long address range first.
    task automatic begin_search_round(input bit from_top, inout t_result r);
        logic [24:0] sum;
        if (from_top) begin
            seq_min = '0;
            seq_max = SEARCH_TOP;
        end
        sum       = {1'b0, seq_min} + {1'b0, seq_max};
        seq_mid   = sum[24:1];
        r.frame   = frame_of(FWD_SRCH_H, seq_mid[23:16], 1'b0, 1'b0, PRIO_TRANSACTION);
        seq_phase = PH_SEARCH_H;
    endtask

    // Applies one accepted event to the mirror and gives the result it causes.
    task automatic advance_sequencer(input t_op op, input logic [2:0] rc,
                                     output t_result r);
        r = '0;
        case (op)
            OP_START: begin
                if (seq_phase == PH_INACTIVE) begin
                    events_applied++;
                    seq_min   = '0;
                    seq_max   = '0;
                    seq_mid   = '0;
                    seq_short = '0;
                    seq_wait  = '0;
                    r.frame   = frame_of(FWD_BCAST, cfg_shadow.reset_command,
                                         1'b0, 1'b0, PRIO_CONFIG);
                    seq_phase = PH_RESET;
                end
            end
            OP_RESULT: begin
                if (seq_phase != PH_INACTIVE && seq_phase != PH_RESET_WAIT &&
                    seq_phase != PH_RANDOMISE_WAIT) begin
                    events_applied++;
                    if (!rc_accepted(seq_phase, rc)) begin
                        conclude(1'b0, r);
                    end else begin
                        case (seq_phase)
                            PH_RESET: begin
                                seq_phase = PH_RESET_WAIT;
                                seq_wait  = '0;
                            end
                            PH_LAMP_OFF: begin
                                r.frame   = frame_of(FWD_INIT, 8'h00, 1'b1, 1'b0,
                                                     PRIO_TRANSACTION);
                                seq_phase = PH_INITIALISE;
                            end
                            PH_INITIALISE: begin
                                r.frame   = frame_of(FWD_RAND, 8'h00, 1'b1, 1'b0,
                                                     PRIO_TRANSACTION);
                                seq_phase = PH_RANDOMISE;
                            end
                            PH_RANDOMISE: begin
                                // The randomise wait counts from zero again.
                                seq_phase = PH_RANDOMISE_WAIT;
                                seq_wait  = '0;
                            end
                            PH_SEARCH_H: begin
                                r.frame   = frame_of(FWD_SRCH_M, seq_mid[15:8], 1'b0, 1'b0,
                                                     PRIO_TRANSACTION);
                                seq_phase = PH_SEARCH_M;
                            end
                            PH_SEARCH_M: begin
                                r.frame   = frame_of(FWD_SRCH_L, seq_mid[7:0], 1'b0, 1'b0,
                                                     PRIO_TRANSACTION);
                                seq_phase = PH_SEARCH_L;
                            end
                            PH_SEARCH_L: begin
                                r.frame   = frame_of(FWD_CMP, 8'h00, 1'b0, 1'b1,
                                                     PRIO_TRANSACTION);
                                seq_phase = PH_COMPARE;
                            end
                            PH_COMPARE: begin
                                if (rc == RC_NO_REPLY) begin
                                    // Nobody at or below the midpoint: move the floor up.
                                    seq_min = seq_mid + 24'd1;
                                    if (seq_min > seq_max)
                                        conclude(1'b1, r);
                                    else
                                        begin_search_round(1'b0, r);
                                end else if (seq_min == seq_max) begin
                                    r.frame   = frame_of(FWD_PROG, {seq_short, 1'b1},
                                                         1'b0, 1'b0, PRIO_TRANSACTION);
                                    seq_phase = PH_PROGRAM;
                                end else begin
                                    seq_max = seq_mid;
                                    begin_search_round(1'b0, r);
                                end
                            end
                            PH_PROGRAM: begin
                                r.frame   = frame_of(FWD_VERIFY, {seq_short, 1'b1},
                                                     1'b0, 1'b1, PRIO_TRANSACTION);
                                seq_phase = PH_VERIFY;
                                seq_short = seq_short + 7'd1;
                            end
                            PH_VERIFY: begin
                                r.frame   = frame_of(FWD_WDRAW, 8'h00, 1'b0, 1'b0,
                                                     PRIO_TRANSACTION);
                                seq_phase = PH_WITHDRAW;
                            end
                            PH_WITHDRAW: begin
                                begin_search_round(1'b1, r);
                            end
                            default: ;
                        endcase
                    end
                end
            end
            OP_TICK: begin
                if (seq_phase == PH_RESET_WAIT || seq_phase == PH_RANDOMISE_WAIT) begin
                    events_applied++;
                    if (seq_wait != WAIT_MAX)
                        seq_wait = seq_wait + 16'd1;
                    if (seq_phase == PH_RESET_WAIT) begin
                        if (seq_wait >= cfg_shadow.reset_wait_ticks) begin
                            r.frame   = frame_of(FWD_BCAST, cfg_shadow.off_command,
                                                 1'b1, 1'b0, PRIO_TRANSACTION);
                            seq_phase = PH_LAMP_OFF;
                        end
                    end else if (seq_wait >= cfg_shadow.randomise_wait_ticks) begin
                        begin_search_round(1'b1, r);
                    end
                end
            end
            default: ;
        endcase
        r.busy_res    = (seq_phase != PH_INACTIVE);
        r.lamps_found = seq_short;
        r.search_low  = seq_min;
    endtask

    // ------------------------------------------------------------------------
    // Stimulus side
    // ------------------------------------------------------------------------

    // Sends one event. Inputs change on the falling edge; the transfer is
    // taken at the first rising edge with o_ready high, and its result is
    // predicted right there. The valid stays high into the next call, so
    // back-to-back events get one assignment per edge.
    task automatic send_event(input t_op op, input logic [2:0] rc);
        t_result r;
        @(negedge i_clk);
        while ($urandom_range(0, 99) < tx_idle_pct) begin
            i_valid <= 1'b0;
            @(negedge i_clk);
        end
        i_valid       <= 1'b1;
        i_op          <= op;
        i_result_code <= rc;
        do @(posedge i_clk); while (!o_ready);
        advance_sequencer(op, rc, r);
        frames_due.insert(frames_due.size(), r);
    endtask

    // Drops the valid and holds off until every predicted result has been
    // taken.
    task automatic drain;
        @(negedge i_clk);
        i_valid <= 1'b0;
        while (frames_due.size() != 0)
            @(posedge i_clk);
        repeat (4) @(posedge i_clk);
    endtask

    // Register write; only called while no event is being sent, so the mirror
    // can be updated right away.
    task automatic cfg_write(input logic [CFG_INDEX_W-1:0] idx,
                             input logic [CFG_DATA_W-1:0] data);
        @(negedge i_clk);
        i_cfg_we    <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= data;
        @(negedge i_clk);
        i_cfg_we    <= 1'b0;
        case (idx)
            CFG_RESET_WAIT:     cfg_shadow.reset_wait_ticks     = data;
            CFG_RANDOMISE_WAIT: cfg_shadow.randomise_wait_ticks = data;
            CFG_RESET_CMD:      cfg_shadow.reset_command        = data[7:0];
            CFG_OFF_CMD:        cfg_shadow.off_command          = data[7:0];
            default: ;
        endcase
    endtask

    // Runs one addressing sequence from start until the mirror says it has
    // ended. Events are mostly what a bus full of lamps would answer; noise
    // (per mille) is a fully random event, a fault is a rejected result code.
    task automatic run_episode(input int noise_pm, input int fault_pm);
        t_op        op;
        logic [2:0] rc;
        int         pick;
        bit         lamp_low;
        send_event(OP_START, 3'($urandom_range(0, 7)));
        while (seq_phase != PH_INACTIVE) begin
            pick = $urandom_range(0, 999);
            rc   = RC_SUCCESS;
            op   = OP_RESULT;
            if (pick < noise_pm) begin
                op = t_op'($urandom_range(0, 3));
                rc = 3'($urandom_range(0, 7));
            end else if (seq_phase == PH_RESET_WAIT || seq_phase == PH_RANDOMISE_WAIT) begin
                op = OP_TICK;
                rc = 3'($urandom_range(0, 7));
            end else if (pick < noise_pm + fault_pm) begin
                do rc = 3'($urandom_range(0, 7)); while (rc_accepted(seq_phase, rc));
            end else begin
                case (seq_phase)
                    PH_COMPARE: begin
                        // Any lamp at or below the midpoint answers; the
                        // answer may be garbled, which still counts as a reply.
                        lamp_low = 1'b0;
                        foreach (lamp_addrs[k])
                            if (lamp_addrs[k] <= seq_mid)
                                lamp_low = 1'b1;
                        rc = lamp_low ? 3'($urandom_range(RC_GOOD_REPLY, RC_TIMING_ERROR))
                                      : RC_NO_REPLY;
                    end
                    PH_VERIFY: rc = RC_GOOD_REPLY;
                    PH_WITHDRAW: begin
                        // The lamp just programmed leaves the search.
                        for (int k = 0; k < lamp_addrs.size(); k++) begin
                            if (lamp_addrs[k] == seq_min) begin
                                lamp_addrs.delete(k);
                                break;
                            end
                        end
                    end
                    default: ;
                endcase
            end
            send_event(op, rc);
        end
        lamp_addrs.delete();
    endtask

    // Events that the inactive sequencer must ignore: op three, a result
    // and a tick. Each still yields a status-only result.
    task automatic test_idle_events;
        send_event(OP_NONE, 3'd7);
        send_event(OP_RESULT, RC_SUCCESS);
        send_event(OP_TICK, RC_GOOD_REPLY);
    endtask

    // A start while busy is ignored; a failure before initialise ends the
    // sequence without a terminate frame.
    task automatic test_early_failure;
        send_event(OP_START, RC_SUCCESS);
        send_event(OP_START, RC_SUCCESS);
        send_event(OP_RESULT, RC_SEND_FAILED);
    endtask

    // One full search for a single lamp with the register reset values,
    // including the two long waits.
    task automatic test_default_waits;
        drain;
        lamp_addrs.insert(lamp_addrs.size(), 24'($urandom_range(0, SEARCH_TOP)));
        run_episode(0, 0);
    endtask

    // Zero-length waits, extreme command bytes, a failure after initialise
    // with an out-of-range code, and a failure inside the search.
    task automatic test_late_failure;
        drain;
        cfg_write(CFG_RESET_WAIT, 16'h0000);
        cfg_write(CFG_RANDOMISE_WAIT, 16'h0000);
        cfg_write(CFG_RESET_CMD, 16'hFF00);
        cfg_write(CFG_OFF_CMD, 16'hFFFF);
        send_event(OP_START, RC_SUCCESS);
        send_event(OP_RESULT, RC_SUCCESS);
        send_event(OP_TICK, RC_SUCCESS);
        send_event(OP_RESULT, RC_SUCCESS);
        send_event(OP_RESULT, 3'd7);
        send_event(OP_START, RC_SUCCESS);
        send_event(OP_RESULT, RC_SUCCESS);
        send_event(OP_RESULT, RC_SUCCESS);
        send_event(OP_TICK, RC_SUCCESS);
        send_event(OP_RESULT, RC_SUCCESS);
        send_event(OP_RESULT, RC_SUCCESS);
        send_event(OP_RESULT, RC_SUCCESS);
        send_event(OP_RESULT, RC_SUCCESS);
        send_event(OP_TICK, RC_SUCCESS);
        send_event(OP_RESULT, 3'd6);
    endtask

    // Random sequences under changing settings until about `budget` events
    // have had an effect. Each sequence begins with the sender paused until
    // all earlier results are in, which is also when registers are written.
    task automatic test_random_traffic(input int budget);
        int target;
        int lamps;
        target = events_applied + budget;
        while (events_applied < target) begin
            drain;
            if ($urandom_range(0, 1))
                cfg_write(CFG_RESET_WAIT, ($urandom_range(0, 7) == 0) ? 16'd0
                                                                      : 16'($urandom_range(1, 5)));
            if ($urandom_range(0, 1))
                cfg_write(CFG_RANDOMISE_WAIT, ($urandom_range(0, 7) == 0) ? 16'd0
                                                                          : 16'($urandom_range(1, 5)));
            if ($urandom_range(0, 1))
                cfg_write(CFG_RESET_CMD, 16'($urandom()));
            if ($urandom_range(0, 1))
                cfg_write(CFG_OFF_CMD, 16'($urandom()));
            lamps = $urandom_range(0, 3);
            repeat (lamps) begin
                case ($urandom_range(0, 5))
                    0:       lamp_addrs.insert(lamp_addrs.size(), 24'h000000);
                    1:       lamp_addrs.insert(lamp_addrs.size(), SEARCH_TOP);
                    default: lamp_addrs.insert(lamp_addrs.size(),
                                               24'($urandom_range(0, SEARCH_TOP)));
                endcase
            end
            // One sequence in eight has noise on about 40 percent of its events.
            run_episode(($urandom_range(0, 7) == 0) ? 400 : 30, 8);
        end
    endtask

    // Both waits at their largest value: a few ticks must not move the
    // sequencer on. The reset wait is then shortened while it is running,
    // and the lamp off frame is answered with a failure.
    task automatic test_longest_waits;
        drain;
        cfg_write(CFG_RESET_WAIT, 16'hFFFF);
        cfg_write(CFG_RANDOMISE_WAIT, 16'hFFFF);
        send_event(OP_START, RC_SUCCESS);
        send_event(OP_RESULT, RC_SUCCESS);
        repeat (20) send_event(OP_TICK, RC_SUCCESS);
        drain;
        cfg_write(CFG_RESET_WAIT, 16'd22);
        while (seq_phase == PH_RESET_WAIT)
            send_event(OP_TICK, RC_SUCCESS);
        send_event(OP_RESULT, RC_SEND_FAILED);
    endtask

    // ------------------------------------------------------------------------
    // Result side
    // ------------------------------------------------------------------------

    // The result receiver holds off at random.
    always @(negedge i_clk) begin
        i_ready <= ($urandom_range(0, 99) >= rx_idle_pct);
    end

    // Prints one line per mismatch and counts it.
    task automatic report_mismatch(input string msg);
        $display("mismatch at %0t: %s", $realtime, msg);
        mismatches++;
    endtask

    task automatic check_field(input string name, input logic [23:0] got,
                               input logic [23:0] want);
        if (got !== want)
            report_mismatch($sformatf("%s got %0h expected %0h", name, got, want));
    endtask

    // Every result transfer is matched with the oldest prediction.
    always @(posedge i_clk) begin
        if (i_rst_n && o_valid && i_ready) begin
            if (frames_due.size() == 0) begin
                report_mismatch($sformatf("result with no event pending, address %0h",
                                          o_cmd_address));
            end else begin
                due = frames_due[0];
                frames_due.delete(0);
                check_field("cmd_valid", 24'(o_cmd_valid), 24'(due.frame.valid));
                check_field("cmd_address", 24'(o_cmd_address), 24'(due.frame.address));
                check_field("cmd_data", 24'(o_cmd_data), 24'(due.frame.data));
                check_field("cmd_twice", 24'(o_cmd_twice), 24'(due.frame.twice));
                check_field("cmd_expect_reply", 24'(o_cmd_expect_reply),
                            24'(due.frame.expect_reply));
                check_field("cmd_priority", 24'(o_cmd_priority),
                            24'(due.frame.priority_code));
                check_field("busy_res", 24'(o_busy_res), 24'(due.busy_res));
                check_field("finished_ok", 24'(o_finished_ok), 24'(due.finished_ok));
                check_field("finished_fail", 24'(o_finished_fail), 24'(due.finished_fail));
                check_field("lamps_found", 24'(o_lamps_found), 24'(due.lamps_found));
                check_field("search_low", o_search_low, due.search_low);
            end
        end
    end

    // ------------------------------------------------------------------------
    // Test sequence
    // ------------------------------------------------------------------------
    initial begin
        repeat (8) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        // Sender idles lightly, receiver heavily.
        tx_idle_pct = 36;
        rx_idle_pct = 69;
        test_idle_events;
        test_early_failure;
        test_default_waits;
        test_late_failure;
        test_random_traffic(250);

        // The other way round.
        tx_idle_pct = 69;
        rx_idle_pct = 36;
        test_random_traffic(250);

        // Full rate on both sides, ending with the largest wait values.
        tx_idle_pct = 0;
        rx_idle_pct = 0;
        test_random_traffic(250);
        test_longest_waits;

        drain;
        repeat (20) @(posedge i_clk);
        if (mismatches == 0 && frames_due.size() == 0) begin
            $display("PASS");
        end else begin
            $display("FAIL");
        end
        $finish;
    end

    // Watchdog: the slowest correct run needs well under a tenth of this.
    initial begin
        #2000000;
        $display("FAIL");
        $finish;
    end

endmodule

/* files.f */
rtl/core/dasu_pkg.sv
rtl/core/dasu_step.sv
rtl/core/dasu_out_buf.sv
rtl/core/dali_address_search_sequencer_unit.sv
tb/dali_address_search_sequencer_unit_test.sv
